@@ rtl/core/epoch_calendar_register_read_top_assert.svh @@
// Assertion macros for the epoch calendar register read block.
`ifndef EPOCH_CALENDAR_REGISTER_READ_TOP_ASSERT_SVH
`define EPOCH_CALENDAR_REGISTER_READ_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define EPCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epcr: implication check failed");

`define EPCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epcr: next-cycle check failed");

`else

`define EPCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EPCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/epcr_pkg.sv @@
// Shared types, constants and tables for the epoch calendar register read block.
`timescale 1ns / 1ps

package epcr_pkg;

    // pipeline depth: 3 split stages, 11 calendar stages, 1 output stage
    localparam int unsigned NS       = 15;
    localparam int unsigned STG_TOD  = 6;   // first stage of the time-of-day delay line
    localparam int unsigned STG_LAST = NS - 1;

    // APB map
    localparam int unsigned ADDR_W    = 3;
    localparam logic [0:0]  REG_START = 1'b0;

    localparam int unsigned FIELD_COUNT = 9;

    typedef enum logic [3:0] {
        FLD_SEC  = 4'd0,
        FLD_MIN  = 4'd1,
        FLD_HOUR = 4'd2,
        FLD_MDAY = 4'd3,
        FLD_MON  = 4'd4,
        FLD_YEAR = 4'd5,
        FLD_CENT = 4'd6,
        FLD_WDAY = 4'd7,
        FLD_YDAY = 4'd8,
        FLD_NONE = 4'd15
    } t_field;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] wday;
    } t_tod;

    typedef struct packed {
        logic [4:0] mday;
        logic [3:0] mon;
        logic [6:0] yy;
        logic [4:0] cent;
        logic [8:0] yday;
    } t_date;

    // calendar constants
    localparam logic [19:0] EPOCH_SHIFT = 20'd719468;  // days from 0000-03-01 to 1970-01-01
    localparam logic [19:0] DAYS_ERA    = 20'd146097;  // days in 400 years

    // reciprocals: floor(x / d) == (x * M) >> K for every x in range
    localparam logic [26:0] M_DAY  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
    localparam logic [17:0] M_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [17:0] M_MIN  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [17:0] M_WEEK = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
    localparam logic [20:0] M_ERA  = 21'(((64'd1 << 38) + 64'd146096) / 64'd146097);
    localparam logic [25:0] M_4Y   = 26'(((64'd1 << 36) + 64'd1459) / 64'd1460);
    localparam logic [20:0] M_CENT = 21'(((64'd1 << 36) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_400  = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
    localparam logic [18:0] M_YEAR = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_Y100 = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_MP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [12:0] M_C100 = 13'(((64'd1 << 19) + 64'd99) / 64'd100);

    // first day of each March-based month, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/epcr_in_if.sv @@
// Request channel: elapsed seconds and register offset.
`timescale 1ns / 1ps

interface epcr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_seconds;
    logic [7:0]  reg_offset;

    modport source (output valid, output elapsed_seconds, output reg_offset, input ready);
    modport sink   (input valid, input elapsed_seconds, input reg_offset, output ready);
endinterface

@@ rtl/core/epcr_out_if.sv @@
// Response channel: selected calendar field.
`timescale 1ns / 1ps

interface epcr_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

@@ rtl/core/epoch_calendar_register_read_top.sv @@
// Epoch calendar register read: top level with APB start register and pipeline control.
// Throughput: one item per cycle while o_out.ready holds; the pipeline has 15 stages.
// Stalls back up stage by stage, so empty stages keep accepting items.
// Reset (synchronous, active low) clears all stage valid bits and start_seconds to 0.
`timescale 1ns / 1ps
`include "epoch_calendar_register_read_top_assert.svh"

module epoch_calendar_register_read_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    epcr_in_if.sink                       i_in,
    epcr_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [epcr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned NS = epcr_pkg::NS;
    localparam logic [NS-1:0] ALL_ONES = '1;

    // ---------------------------------------------------------------
    // Configuration: start epoch in seconds, register 0
    // ---------------------------------------------------------------
    logic [31:0] r_start;
    logic        n_cfg_wr;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite &&
                      (paddr[epcr_pkg::ADDR_W-1:2] == epcr_pkg::REG_START);
    assign prdata   = (paddr[epcr_pkg::ADDR_W-1:2] == epcr_pkg::REG_START) ? r_start : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 32'd0;
        end else if (n_cfg_wr) begin
            r_start <= pwdata;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control. Stage s loads when it is empty or the stage
    // above it moves, i.e. some stage from s up is empty or the
    // output is taken. Stage 14 is the output register.
    // ---------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_en[s] = o_out.ready | ~&(r_v | (ALL_ONES >> (NS - s)));
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // field select travels with the item
    epcr_pkg::t_field r_sel [NS];
    epcr_pkg::t_field n_sel;

    assign n_sel = (i_in.reg_offset < 8'(epcr_pkg::FIELD_COUNT)) ?
                   epcr_pkg::t_field'(i_in.reg_offset[3:0]) : epcr_pkg::FLD_NONE;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sel[0] <= n_sel;
        end
        for (int s = 1; s < NS; s++) begin
            if (w_en[s]) begin
                r_sel[s] <= r_sel[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic [16:0]     w_days;
    logic [16:0]     w_sod;
    epcr_pkg::t_tod  w_tod;
    epcr_pkg::t_date w_date;

    // stages 0..2: sum, divide by seconds per day
    epcr_split u_split (
        .i_clk     (i_clk),
        .i_en      (w_en[2:0]),
        .i_start   (r_start),
        .i_elapsed (i_in.elapsed_seconds),
        .o_days    (w_days),
        .o_sod     (w_sod)
    );

    // stages 3..5: time of day and weekday
    epcr_clock u_clock (
        .i_clk  (i_clk),
        .i_en   (w_en[5:3]),
        .i_days (w_days),
        .i_sod  (w_sod),
        .o_tod  (w_tod)
    );

    // stages 3..13: calendar date
    epcr_date u_date (
        .i_clk  (i_clk),
        .i_en   (w_en[13:3]),
        .i_days (w_days),
        .o_date (w_date)
    );

    // stages 6..13: time of day waits for the date
    epcr_pkg::t_tod r_tod [epcr_pkg::STG_TOD:NS-2];

    always_ff @(posedge i_clk) begin
        if (w_en[epcr_pkg::STG_TOD]) begin
            r_tod[epcr_pkg::STG_TOD] <= w_tod;
        end
        for (int s = epcr_pkg::STG_TOD + 1; s <= NS - 2; s++) begin
            if (w_en[s]) begin
                r_tod[s] <= r_tod[s-1];
            end
        end
    end

    // stage 14: field select into the output register
    logic [8:0] r_out;
    logic [8:0] n_out;

    always_comb begin
        case (r_sel[NS-2])
            epcr_pkg::FLD_SEC:  n_out = 9'(r_tod[NS-2].sec);
            epcr_pkg::FLD_MIN:  n_out = 9'(r_tod[NS-2].minute);
            epcr_pkg::FLD_HOUR: n_out = 9'(r_tod[NS-2].hour);
            epcr_pkg::FLD_MDAY: n_out = 9'(w_date.mday);
            epcr_pkg::FLD_MON:  n_out = 9'(w_date.mon);
            epcr_pkg::FLD_YEAR: n_out = 9'(w_date.yy);
            epcr_pkg::FLD_CENT: n_out = 9'(w_date.cent);
            epcr_pkg::FLD_WDAY: n_out = 9'(r_tod[NS-2].wday);
            epcr_pkg::FLD_YDAY: n_out = w_date.yday;
            default:            n_out = 9'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[epcr_pkg::STG_LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_v[epcr_pkg::STG_LAST];
    assign o_out.read_data = r_out;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `EPCR_ASSERT_IMP(a_blocked_means_full, i_clk, i_rst_n, !i_in.ready, &r_v)
    `EPCR_ASSERT_NXT(a_stall_keeps_last, i_clk, i_rst_n, o_out.valid && !o_out.ready && r_v[NS-2], r_v[NS-2])
    `EPCR_ASSERT_IMP(a_unknown_reads_zero, i_clk, i_rst_n, o_out.valid && (r_sel[NS-1] == epcr_pkg::FLD_NONE), o_out.read_data == 9'd0)
    `EPCR_ASSERT_IMP(a_sec_min_range, i_clk, i_rst_n, o_out.valid && (r_sel[NS-1] == epcr_pkg::FLD_SEC || r_sel[NS-1] == epcr_pkg::FLD_MIN), o_out.read_data < 9'd60)
    `EPCR_ASSERT_IMP(a_wday_nonzero, i_clk, i_rst_n, r_v[NS-2], r_tod[NS-2].wday != 3'd0)

endmodule

@@ rtl/core/epcr_split.sv @@
// Adds the start epoch and splits seconds into whole days and second of day.
`timescale 1ns / 1ps

module epcr_split (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_start,
    input  logic [31:0] i_elapsed,
    output logic [16:0] o_days,
    output logic [16:0] o_sod
);

    logic [32:0] r_total;
    logic [52:0] r_prod;
    logic [25:0] r_q;
    logic [6:0]  r_low;
    logic [16:0] r_days;
    logic [16:0] r_sod;

    logic [52:0] n_prod;
    logic [16:0] n_days;
    logic [25:0] n_rem;

    // 86400 = 128 * 675: divide the upper bits by 675
    assign n_prod = 53'(r_total[32:7]) * 53'(epcr_pkg::M_DAY);
    assign n_days = r_prod[52:36];
    assign n_rem  = r_q - 26'(27'(n_days) * 27'(675));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_total <= {1'b0, i_start} + {1'b0, i_elapsed};
        end
        if (i_en[1]) begin
            r_prod <= n_prod;
            r_q    <= r_total[32:7];
            r_low  <= r_total[6:0];
        end
        if (i_en[2]) begin
            r_days <= n_days;
            r_sod  <= {n_rem[9:0], r_low};
        end
    end

    assign o_days = r_days;
    assign o_sod  = r_sod;

endmodule

@@ rtl/core/epcr_clock.sv @@
// Hour, minute, second and weekday from second of day and day count.
`timescale 1ns / 1ps

module epcr_clock (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  logic [16:0]        i_days,
    input  logic [16:0]        i_sod,
    output epcr_pkg::t_tod     o_tod
);

    logic [34:0] r_ph;
    logic [34:0] r_pm;
    logic [34:0] r_pw;
    logic [16:0] r_sod;
    logic [16:0] r_w;
    logic [4:0]  r_hour;
    logic [10:0] r_mtot;
    logic [5:0]  r_sec;
    logic [2:0]  r_wday;
    epcr_pkg::t_tod r_tod;

    logic [16:0] n_w;
    logic [4:0]  n_hour;
    logic [10:0] n_mtot;
    logic [13:0] n_q7;
    logic [5:0]  n_sec;
    logic [2:0]  n_wday;
    logic [5:0]  n_min;

    // 1970-01-01 was a Thursday
    assign n_w    = i_days + 17'd3;
    assign n_hour = r_ph[33:29];
    assign n_mtot = r_pm[33:23];
    assign n_q7   = r_pw[33:20];
    assign n_sec  = 6'(r_sod - 17'(n_mtot) * 17'(60));
    assign n_wday = 3'(r_w - 17'(n_q7) * 17'(7) + 17'd1);
    assign n_min  = 6'(r_mtot - 11'(r_hour) * 11'(60));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ph  <= 35'(i_sod) * 35'(epcr_pkg::M_HOUR);
            r_pm  <= 35'(i_sod) * 35'(epcr_pkg::M_MIN);
            r_pw  <= 35'(n_w) * 35'(epcr_pkg::M_WEEK);
            r_sod <= i_sod;
            r_w   <= n_w;
        end
        if (i_en[1]) begin
            r_hour <= n_hour;
            r_mtot <= n_mtot;
            r_sec  <= n_sec;
            r_wday <= n_wday;
        end
        if (i_en[2]) begin
            r_tod.sec    <= r_sec;
            r_tod.minute <= n_min;
            r_tod.hour   <= r_hour;
            r_tod.wday   <= r_wday;
        end
    end

    assign o_tod = r_tod;

endmodule

@@ rtl/core/epcr_date.sv @@
// Day count to Gregorian date fields, March-based era algorithm.
`timescale 1ns / 1ps

module epcr_date (
    input  logic            i_clk,
    input  logic [10:0]     i_en,
    input  logic [16:0]     i_days,
    output epcr_pkg::t_date o_date
);

    // stage 0
    logic [19:0] r0_z;
    logic [40:0] r0_pe;
    // stage 1
    logic [2:0]  r1_era;
    logic [17:0] r1_doe;
    // stage 2
    logic [43:0] r2_pa;
    logic [38:0] r2_pb;
    logic [36:0] r2_pc;
    logic [17:0] r2_doe;
    logic [2:0]  r2_era;
    // stage 3
    logic [17:0] r3_t;
    logic [17:0] r3_doe;
    logic [2:0]  r3_era;
    // stage 4
    logic [36:0] r4_pt;
    logic [17:0] r4_doe;
    logic [2:0]  r4_era;
    // stage 5
    logic [8:0]  r5_yoe;
    logic [17:0] r5_y365;
    logic [17:0] r5_doe;
    logic [2:0]  r5_era;
    // stage 6
    logic [8:0]  r6_doy;
    logic [11:0] r6_ybase;
    // stage 7
    logic [22:0] r7_px;
    logic [8:0]  r7_doy;
    logic [11:0] r7_ybase;
    // stage 8
    logic [4:0]  r8_mday;
    logic [3:0]  r8_mon;
    logic [11:0] r8_year;
    logic [8:0]  r8_doy;
    logic        r8_march;
    // stage 9
    logic [24:0] r9_py;
    logic [4:0]  r9_mday;
    logic [3:0]  r9_mon;
    logic [11:0] r9_year;
    logic [8:0]  r9_doy;
    logic        r9_march;
    // stage 10
    epcr_pkg::t_date r10_date;

    logic [19:0] n_z;
    logic [2:0]  n_era;
    logic [17:0] n_doe;
    logic [17:0] n_t;
    logic [8:0]  n_yoe;
    logic [17:0] n_y365;
    logic [18:0] n_p100;
    logic [8:0]  n_doy;
    logic [11:0] n_ybase;
    logic [10:0] n_x;
    logic [3:0]  n_mp;
    logic        n_march;
    logic [3:0]  n_mon;
    logic [4:0]  n_mday;
    logic [11:0] n_year;
    logic [4:0]  n_cent;
    logic [6:0]  n_yy;
    logic        n_leap;
    logic [8:0]  n_yday;

    assign n_z   = 20'(i_days) + epcr_pkg::EPOCH_SHIFT;
    assign n_era = r0_pe[40:38];
    assign n_doe = 18'(r0_z - 20'(n_era) * epcr_pkg::DAYS_ERA);

    // doe - doe/1460 + doe/36524 - doe/146096
    assign n_t = r2_doe - 18'(r2_pa[42:36]) + 18'(r2_pb[38:36]) - 18'(r2_pc[36]);

    assign n_yoe  = r4_pt[35:27];
    assign n_y365 = 18'(n_yoe) * 18'(365) + 18'(n_yoe[8:2]);

    assign n_p100  = 19'(r5_yoe) * 19'(epcr_pkg::M_Y100);
    assign n_doy   = 9'(r5_doe - r5_y365 + 18'(n_p100[18:16]));
    assign n_ybase = 12'(r5_yoe) + 12'(r5_era) * 12'(400);

    assign n_x = 11'(r6_doy) * 11'(5) + 11'd2;

    assign n_mp    = r7_px[22:19];
    assign n_march = (n_mp < 4'd10);
    assign n_mon   = n_march ? n_mp + 4'd3 : n_mp - 4'd9;
    assign n_mday  = 5'(r7_doy - epcr_pkg::month_start(n_mp) + 9'd1);
    assign n_year  = r7_ybase + 12'(!n_march);

    assign n_cent = r9_py[23:19];
    assign n_yy   = 7'(r9_year - 12'(n_cent) * 12'(100));
    assign n_leap = ((r9_year[1:0] == 2'd0) && (n_yy != 7'd0)) ||
                    ((n_yy == 7'd0) && (n_cent[1:0] == 2'd0));
    // one-based day of year; March onward follows January and February
    assign n_yday = r9_march ? r9_doy + 9'd60 + 9'(n_leap) : r9_doy - 9'd305;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_z  <= n_z;
            r0_pe <= 41'(n_z) * 41'(epcr_pkg::M_ERA);
        end
        if (i_en[1]) begin
            r1_era <= n_era;
            r1_doe <= n_doe;
        end
        if (i_en[2]) begin
            r2_pa  <= 44'(r1_doe) * 44'(epcr_pkg::M_4Y);
            r2_pb  <= 39'(r1_doe) * 39'(epcr_pkg::M_CENT);
            r2_pc  <= 37'(r1_doe) * 37'(epcr_pkg::M_400);
            r2_doe <= r1_doe;
            r2_era <= r1_era;
        end
        if (i_en[3]) begin
            r3_t   <= n_t;
            r3_doe <= r2_doe;
            r3_era <= r2_era;
        end
        if (i_en[4]) begin
            r4_pt  <= 37'(r3_t) * 37'(epcr_pkg::M_YEAR);
            r4_doe <= r3_doe;
            r4_era <= r3_era;
        end
        if (i_en[5]) begin
            r5_yoe  <= n_yoe;
            r5_y365 <= n_y365;
            r5_doe  <= r4_doe;
            r5_era  <= r4_era;
        end
        if (i_en[6]) begin
            r6_doy   <= n_doy;
            r6_ybase <= n_ybase;
        end
        if (i_en[7]) begin
            r7_px    <= 23'(n_x) * 23'(epcr_pkg::M_MP);
            r7_doy   <= r6_doy;
            r7_ybase <= r6_ybase;
        end
        if (i_en[8]) begin
            r8_mday  <= n_mday;
            r8_mon   <= n_mon;
            r8_year  <= n_year;
            r8_doy   <= r7_doy;
            r8_march <= n_march;
        end
        if (i_en[9]) begin
            r9_py    <= 25'(r8_year) * 25'(epcr_pkg::M_C100);
            r9_mday  <= r8_mday;
            r9_mon   <= r8_mon;
            r9_year  <= r8_year;
            r9_doy   <= r8_doy;
            r9_march <= r8_march;
        end
        if (i_en[10]) begin
            r10_date.mday <= r9_mday;
            r10_date.mon  <= r9_mon;
            r10_date.yy   <= n_yy;
            r10_date.cent <= n_cent;
            r10_date.yday <= n_yday;
        end
    end

    assign o_date = r10_date;

endmodule
